// ----- rtl/ofg_pkg.sv -----
// Package for the observation freshness guard: operation codes, register
// indexes, reset values, the guard state and result word types, and the scale clamp.
// Depends on nothing.
package ofg_pkg;

   // Codes of the operation field. The fourth code changes nothing.
   typedef enum logic [1:0] {
      OP_OBSERVE    = 2'd0,
      OP_TICK       = 2'd1,
      OP_INVALIDATE = 2'd2
   } op_type;

   // Indexes of the configuration registers.
   typedef enum logic {
      CSR_MAX_AGE_US    = 1'b0,
      CSR_TIMEOUT_TICKS = 1'b1
   } csr_index_type;

   localparam logic [31:0] MAX_AGE_US_RESET    = 32'd200000;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd50;
   localparam logic [1:0]  WARMUP_GOOD         = 2'd3;
   localparam logic [14:0] SCALE_ONE           = 15'd16384;

   typedef struct packed {
      logic        valid_flag;
      logic [1:0]  warmup_count;
      logic [31:0] last_seq;
      logic [31:0] last_front_time;
      logic [31:0] last_epoch;
      logic [31:0] last_accept_time;
      logic [14:0] scale_held;
      logic [15:0] age_count;
      logic        started_flag;
      logic        latched_flag;
      logic [31:0] timeout_total;
   } guard_state_type;

   typedef struct packed {
      logic        permitted;
      logic        valid_res;
      logic        started;
      logic        stop_latched;
      logic [1:0]  warmup_level;
      logic [15:0] age_level;
      logic [14:0] held_scale;
      logic [31:0] timeouts;
   } result_type;

   // Negative scales are held as zero, scales above 1.0 as 1.0.
   function automatic logic [14:0] clamp_scale(input logic signed [15:0] raw);
      logic [14:0] clamped;
      if (raw[15]) begin
         clamped = 15'd0;
      end else if (raw[14:0] > SCALE_ONE) begin
         clamped = SCALE_ONE;
      end else begin
         clamped = raw[14:0];
      end
      return clamped;
   endfunction

endpackage

// ----- rtl/observation_freshness_guard.sv -----
// Top level of the observation freshness guard: input register, single-pass
// status update, result register and configuration registers.
// Depends on ofg_pkg.

// The guard takes one event word per cycle while req_stall is low
// (observation, guard tick or invalidate) and answers each with exactly one
// status word. A word is held in the input register, the guard state and
// the status are worked out from it in one pass of logic, and the status is
// then held in the result register, which drives the status ports; a steady
// stream runs at one word per cycle while rsp_stall is low. The result register
// and the input register together let one more event be taken while a result
// is held up by rsp_stall. An observation is refused when the stop is latched,
// its epoch is not the current one, it is older than max_age_us or its
// sequence number repeats the last accepted one; a refusal clears the valid
// flag and the warm-up count. Three consecutive good observations make the
// held observation valid, and guard ticks without one latch a stop after
// timeout_ticks. The latch is only cleared by reset. The configuration
// registers must only be written while no event is in flight.
module observation_freshness_guard (
   input  logic               clock,
   input  logic               reset,
   // Event channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [31:0]        req_now_us,
   input  logic [31:0]        req_current_epoch,
   input  logic [31:0]        req_obs_seq,
   input  logic [31:0]        req_obs_time_us,
   input  logic [31:0]        req_obs_epoch,
   input  logic signed [15:0] req_obs_scale,
   // Status channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_permitted,
   output logic               rsp_valid_res,
   output logic               rsp_started,
   output logic               rsp_stop_latched,
   output logic [1:0]         rsp_warmup_level,
   output logic [15:0]        rsp_age_level,
   output logic [14:0]        rsp_held_scale,
   output logic [31:0]        rsp_timeouts,
   // Configuration write port.
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data
);

   // Configuration registers.
   logic [31:0] max_age_ff;
   logic [15:0] timeout_ticks_ff;

   // Input register.
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [1:0]         in_op_ff;
   logic [31:0]        in_now_ff;
   logic [31:0]        in_cur_epoch_ff;
   logic [31:0]        in_seq_ff;
   logic [31:0]        in_front_ff;
   logic [31:0]        in_epoch_ff;
   logic signed [15:0] in_scale_ff;

   // Guard state and result register.
   ofg_pkg::guard_state_type state_ff;
   ofg_pkg::guard_state_type state_in;
   ofg_pkg::result_type      rsp_ff;
   ofg_pkg::result_type      rsp_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   logic req_accept;
   logic advance;

   // Ages and checks on the word in the input register against the old state.
   logic [31:0] obs_age;
   logic [31:0] gap_age;
   logic [31:0] held_age;
   logic [31:0] perm_age;
   logic        obs_reject;
   logic        warmup_restart;
   logic [1:0]  warmup_base;
   logic [1:0]  warmup_next;
   logic [15:0] age_next;

   // ---------------------------------------------------------------------
   // Handshake. The input register moves on whenever the result register
   // is empty or its word is being taken in this cycle. The input side only
   // stalls when the input register is full and cannot move on, so a new
   // word is taken while a finished result still waits.
   // ---------------------------------------------------------------------
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_accept   = req_valid && !req_stall;
   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff        <= req_operation;
         in_now_ff       <= req_now_us;
         in_cur_epoch_ff <= req_current_epoch;
         in_seq_ff       <= req_obs_seq;
         in_front_ff     <= req_obs_time_us;
         in_epoch_ff     <= req_obs_epoch;
         in_scale_ff     <= req_obs_scale;
      end
   end

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff       <= ofg_pkg::MAX_AGE_US_RESET;
         timeout_ticks_ff <= ofg_pkg::TIMEOUT_TICKS_RESET;
      end else if (csr_write_enable) begin
         unique case (ofg_pkg::csr_index_type'(csr_index))
            ofg_pkg::CSR_MAX_AGE_US: begin
               max_age_ff <= csr_write_data;
            end
            ofg_pkg::CSR_TIMEOUT_TICKS: begin
               timeout_ticks_ff <= csr_write_data[15:0];
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Checks. All ages are differences modulo 2^32, so a wrapped clock
   // still gives the right age.
   // ---------------------------------------------------------------------
   assign obs_age  = in_now_ff - in_front_ff;
   assign gap_age  = in_now_ff - state_ff.last_accept_time;
   assign held_age = in_now_ff - state_ff.last_front_time;

   assign obs_reject = state_ff.latched_flag || (in_epoch_ff != in_cur_epoch_ff) ||
                       (obs_age > max_age_ff) || (in_seq_ff == state_ff.last_seq);

   // The warm-up count starts again on a gap in the sequence or a long pause
   // since the last accepted observation.
   assign warmup_restart = (in_seq_ff != (state_ff.last_seq + 32'd1)) ||
                           (gap_age > max_age_ff);
   assign warmup_base    = warmup_restart ? 2'd0 : state_ff.warmup_count;
   assign warmup_next    = (warmup_base < ofg_pkg::WARMUP_GOOD) ?
                           (warmup_base + 2'd1) : ofg_pkg::WARMUP_GOOD;

   // The tick count never passes the timeout, so the increment cannot wrap.
   assign age_next = (state_ff.age_count < timeout_ticks_ff) ?
                     (state_ff.age_count + 16'd1) : state_ff.age_count;

   // ---------------------------------------------------------------------
   // Next guard state.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (ofg_pkg::op_type'(in_op_ff))
         ofg_pkg::OP_OBSERVE: begin
            if (obs_reject) begin
               state_in.valid_flag   = 1'b0;
               state_in.warmup_count = 2'd0;
            end else begin
               state_in.last_seq         = in_seq_ff;
               state_in.last_front_time  = in_front_ff;
               state_in.last_epoch       = in_epoch_ff;
               state_in.last_accept_time = in_now_ff;
               state_in.scale_held       = ofg_pkg::clamp_scale(in_scale_ff);
               state_in.warmup_count     = warmup_next;
               state_in.valid_flag       = (warmup_next == ofg_pkg::WARMUP_GOOD);
               if (warmup_next == ofg_pkg::WARMUP_GOOD) begin
                  state_in.age_count    = 16'd0;
                  state_in.started_flag = 1'b1;
               end
            end
         end
         ofg_pkg::OP_TICK: begin
            // The watchdog only runs once started and until it latches.
            if (state_ff.started_flag && !state_ff.latched_flag) begin
               state_in.age_count = age_next;
               if (age_next >= timeout_ticks_ff) begin
                  state_in.latched_flag  = 1'b1;
                  state_in.timeout_total = state_ff.timeout_total + 32'd1;
               end
            end
            // A held observation of another epoch or grown stale is dropped.
            if ((state_ff.last_epoch != in_cur_epoch_ff) || (held_age > max_age_ff)) begin
               state_in.valid_flag   = 1'b0;
               state_in.warmup_count = 2'd0;
            end
         end
         ofg_pkg::OP_INVALIDATE: begin
            state_in.valid_flag   = 1'b0;
            state_in.warmup_count = 2'd0;
         end
         default: begin
            // The unused code leaves the state as it is.
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Status word, reported on the state after the event.
   // ---------------------------------------------------------------------
   assign perm_age = in_now_ff - state_in.last_front_time;

   always_comb begin
      rsp_in.permitted    = state_in.started_flag && !state_in.latched_flag &&
                            state_in.valid_flag &&
                            (state_in.last_epoch == in_cur_epoch_ff) &&
                            (perm_age <= max_age_ff);
      rsp_in.valid_res    = state_in.valid_flag;
      rsp_in.started      = state_in.started_flag;
      rsp_in.stop_latched = state_in.latched_flag;
      rsp_in.warmup_level = state_in.warmup_count;
      rsp_in.age_level    = state_in.age_count;
      rsp_in.held_scale   = state_in.scale_held;
      rsp_in.timeouts     = state_in.timeout_total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_permitted    = rsp_ff.permitted;
   assign rsp_valid_res    = rsp_ff.valid_res;
   assign rsp_started      = rsp_ff.started;
   assign rsp_stop_latched = rsp_ff.stop_latched;
   assign rsp_warmup_level = rsp_ff.warmup_level;
   assign rsp_age_level    = rsp_ff.age_level;
   assign rsp_held_scale   = rsp_ff.held_scale;
   assign rsp_timeouts     = rsp_ff.timeouts;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // Only reset releases a latched stop.
   a_latch_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff.latched_flag |=> state_ff.latched_flag)
      else $error("stop latch released without reset");

   // The watchdog can only latch once a valid observation has been seen.
   a_latch_needs_start: assert property (@(posedge clock) disable iff (reset)
      state_ff.latched_flag |-> state_ff.started_flag)
      else $error("stop latched before start");

   // A valid observation always goes with a full warm-up count.
   a_valid_warm: assert property (@(posedge clock) disable iff (reset)
      state_ff.valid_flag |-> (state_ff.warmup_count == ofg_pkg::WARMUP_GOOD))
      else $error("valid flag set without full warm-up");

   // The timeout count moves only together with the latch being set.
   a_timeout_with_latch: assert property (@(posedge clock) disable iff (reset)
      !$stable(state_ff.timeout_total) |-> $rose(state_ff.latched_flag))
      else $error("timeout counted without a new latch");

   // A permitted status is never shown together with a stop or without validity.
   a_permit_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_permitted) |-> (rsp_valid_res && rsp_started && !rsp_stop_latched))
      else $error("permitted status contradicts the reported flags");

endmodule
